// ===== rtl/core/lfu_kvc_pkg.sv =====
`default_nettype none

package lfu_kvc_pkg;

   // Default geometry
   localparam int ENTRIES_DEF  = 32;
   localparam int KEY_BITS_DEF = 64;

   // Fixed field widths
   localparam int OPCODE_W    = 2;
   localparam int KEY_FIELD_W = 64;
   localparam int DATA_W      = 64;
   localparam int COUNT_W     = 32;
   localparam int SLOT_W      = 5;

   // Stream packing
   localparam int REQ_TDATA_W = KEY_FIELD_W + DATA_W;
   localparam int RSP_TDATA_W = 72;

   localparam logic [COUNT_W-1:0] HITS_MAX = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_STORE  = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

endpackage

`default_nettype wire

// ===== rtl/core/lfu_kvc_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module lfu_kvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lfu_kvc_scan.sv =====
`default_nettype none

// Match and least-count tracker fed by the RAM read port, one entry a cycle
module lfu_kvc_scan #(
   parameter int ENTRIES  = lfu_kvc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = lfu_kvc_pkg::KEY_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               clear,
   input  wire logic                               cmp_valid,
   input  wire logic [$clog2(ENTRIES)-1:0]         cmp_idx,
   input  wire logic [KEY_BITS-1:0]                key,
   input  wire logic [KEY_BITS-1:0]                rd_key,
   input  wire logic [lfu_kvc_pkg::COUNT_W-1:0]    rd_count,
   input  wire logic [lfu_kvc_pkg::DATA_W-1:0]     rd_value,
   output logic                                    match,
   output logic      [$clog2(ENTRIES)-1:0]         match_idx,
   output logic      [lfu_kvc_pkg::COUNT_W-1:0]    match_count,
   output logic      [lfu_kvc_pkg::DATA_W-1:0]     match_value,
   output logic      [$clog2(ENTRIES)-1:0]         best_idx
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic                             match_ff, match_in;
   logic [IDX_W-1:0]                 match_idx_ff, match_idx_in;
   logic [lfu_kvc_pkg::COUNT_W-1:0]  match_count_ff, match_count_in;
   logic [lfu_kvc_pkg::DATA_W-1:0]   match_value_ff, match_value_in;
   logic [IDX_W-1:0]                 best_idx_ff, best_idx_in;
   logic [lfu_kvc_pkg::COUNT_W-1:0]  best_count_ff, best_count_in;

   // Keys are unique, so the first match is the only one
   always_comb begin
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      match_count_in = match_count_ff;
      match_value_in = match_value_ff;
      best_idx_in    = best_idx_ff;
      best_count_in  = best_count_ff;
      if (clear) begin
         match_in = 1'b0;
      end else if (cmp_valid) begin
         if (!match_ff && rd_key == key) begin
            match_in       = 1'b1;
            match_idx_in   = cmp_idx;
            match_count_in = rd_count;
            match_value_in = rd_value;
         end
         // strict compare keeps the lowest index on a tie
         if (cmp_idx == '0 || rd_count < best_count_ff) begin
            best_idx_in   = cmp_idx;
            best_count_in = rd_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
      match_idx_ff   <= match_idx_in;
      match_count_ff <= match_count_in;
      match_value_ff <= match_value_in;
      best_idx_ff    <= best_idx_in;
      best_count_ff  <= best_count_in;
   end

   assign match       = match_ff;
   assign match_idx   = match_idx_ff;
   assign match_count = match_count_ff;
   assign match_value = match_value_ff;
   assign best_idx    = best_idx_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lfu_key_value_cache.sv =====
`default_nettype none

// Fully associative key/value cache with least-frequently-used eviction.
// Each request (lookup, store or flush in req_tuser) yields exactly one
// response. Lookups and stores scan the valid entries in order from the
// entry RAM, one entry a cycle; flushes, unused opcodes and requests to
// an empty cache skip the scan. The scan rate is set by the single read port
// of the entry RAM. One item is in work at a time; a finished response waits
// in its own register, so the next request is taken while it is pending.
// Keys are compared on their low KEY_BITS bits; slot_used reports the low
// five bits of the entry index. No clearing pass follows reset.
module lfu_key_value_cache #(
   parameter int ENTRIES  = lfu_kvc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = lfu_kvc_pkg::KEY_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // key [63:0], store_value [127:64]
   input  wire logic [lfu_kvc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // opcode [1:0]
   input  wire logic [lfu_kvc_pkg::OPCODE_W-1:0]     req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // hit [0], found_value [64:1], evicted [65], slot_used [70:66], zero [71]
   output logic      [lfu_kvc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int ENTRY_W = lfu_kvc_pkg::COUNT_W + KEY_BITS;
   localparam int DATA_W  = lfu_kvc_pkg::DATA_W;
   localparam int COUNT_W = lfu_kvc_pkg::COUNT_W;
   localparam int SLOT_W  = lfu_kvc_pkg::SLOT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type                state_ff, state_in;
   lfu_kvc_pkg::op_type      op_ff, op_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [DATA_W-1:0]        value_ff, value_in;
   logic [CNT_W-1:0]         entry_count_ff, entry_count_in;
   logic [IDX_W-1:0]         issue_ptr_ff, issue_ptr_in;
   logic                     issue_active_ff, issue_active_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                     rsp_evicted_ff, rsp_evicted_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;

   // RAM ports
   logic                     ent_wr_en, val_wr_en, rd_en;
   logic [IDX_W-1:0]         ent_wr_addr, val_wr_addr;
   logic [ENTRY_W-1:0]       ent_wr_data, ent_rd_data;
   logic [DATA_W-1:0]        val_wr_data, val_rd_data;

   // Scan results
   logic                     scan_clear;
   logic                     match;
   logic [IDX_W-1:0]         match_idx;
   logic [COUNT_W-1:0]       match_count;
   logic [DATA_W-1:0]        match_value;
   logic [IDX_W-1:0]         best_idx;

   logic                     req_accept;
   logic                     issue_last;
   logic                     cache_full;
   logic [IDX_W-1:0]         fill_idx;
   lfu_kvc_pkg::op_type      req_op;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = lfu_kvc_pkg::op_type'(req_tuser);
   assign issue_last = (CNT_W'(issue_ptr_ff) == entry_count_ff - CNT_W'(1));
   assign cache_full = (entry_count_ff == CNT_W'(ENTRIES));
   assign fill_idx   = entry_count_ff[IDX_W-1:0];

   // Entry RAM holds {hit count, key}, value RAM the stored value
   lfu_kvc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ptr_ff),
      .rd_data (ent_rd_data)
   );

   lfu_kvc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ptr_ff),
      .rd_data (val_rd_data)
   );

   lfu_kvc_scan #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (scan_clear),
      .cmp_valid   (cmp_valid_ff),
      .cmp_idx     (cmp_idx_ff),
      .key         (key_ff),
      .rd_key      (ent_rd_data[KEY_BITS-1:0]),
      .rd_count    (ent_rd_data[ENTRY_W-1:KEY_BITS]),
      .rd_value    (val_rd_data),
      .match       (match),
      .match_idx   (match_idx),
      .match_count (match_count),
      .match_value (match_value),
      .best_idx    (best_idx)
   );

   // Sequencer: capture, scan (lookups and stores on a non-empty cache), then read-modify-write and respond
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      value_in        = value_ff;
      entry_count_in  = entry_count_ff;
      issue_ptr_in    = issue_ptr_ff;
      issue_active_in = issue_active_ff;
      cmp_valid_in    = 1'b0;
      cmp_idx_in      = issue_ptr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_slot_in     = rsp_slot_ff;
      scan_clear      = 1'b0;
      rd_en           = 1'b0;
      ent_wr_en       = 1'b0;
      ent_wr_addr     = match_idx;
      ent_wr_data     = {match_count, key_ff};
      val_wr_en       = 1'b0;
      val_wr_addr     = match_idx;
      val_wr_data     = value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in        = req_op;
               key_in       = req_tdata[KEY_BITS-1:0];
               value_in     = req_tdata[lfu_kvc_pkg::REQ_TDATA_W-1:lfu_kvc_pkg::KEY_FIELD_W];
               issue_ptr_in = '0;
               scan_clear   = 1'b1;
               if ((req_op == lfu_kvc_pkg::OP_LOOKUP || req_op == lfu_kvc_pkg::OP_STORE)
                   && entry_count_ff != '0) begin
                  issue_active_in = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_SCAN: begin
            if (issue_active_ff) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               if (issue_last) begin
                  issue_active_in = 1'b0;
               end else begin
                  issue_ptr_in = issue_ptr_ff + IDX_W'(1);
               end
            end else begin
               // last compare completes at this edge
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = 1'b0;
               rsp_value_in   = '0;
               rsp_evicted_in = 1'b0;
               rsp_slot_in    = '0;
               state_in       = ST_IDLE;
               case (op_ff)
                  lfu_kvc_pkg::OP_LOOKUP: begin
                     if (match) begin
                        ent_wr_en    = 1'b1;
                        ent_wr_data  = {(match_count == lfu_kvc_pkg::HITS_MAX) ?
                                        match_count : match_count + COUNT_W'(1), key_ff};
                        rsp_hit_in   = 1'b1;
                        rsp_value_in = match_value;
                        rsp_slot_in  = SLOT_W'(match_idx);
                     end
                  end
                  lfu_kvc_pkg::OP_STORE: begin
                     if (match) begin
                        val_wr_en   = 1'b1;
                        rsp_hit_in  = 1'b1;
                        rsp_slot_in = SLOT_W'(match_idx);
                     end else begin
                        ent_wr_en      = 1'b1;
                        val_wr_en      = 1'b1;
                        ent_wr_addr    = cache_full ? best_idx : fill_idx;
                        val_wr_addr    = cache_full ? best_idx : fill_idx;
                        ent_wr_data    = {COUNT_W'(0), key_ff};
                        rsp_evicted_in = cache_full;
                        rsp_slot_in    = SLOT_W'(cache_full ? best_idx : fill_idx);
                        if (!cache_full) begin
                           entry_count_in = entry_count_ff + CNT_W'(1);
                        end
                     end
                  end
                  lfu_kvc_pkg::OP_FLUSH: begin
                     entry_count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         entry_count_ff  <= '0;
         issue_active_ff <= 1'b0;
         cmp_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         entry_count_ff  <= entry_count_in;
         issue_active_ff <= issue_active_in;
         cmp_valid_ff    <= cmp_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      issue_ptr_ff   <= issue_ptr_in;
      cmp_idx_ff     <= cmp_idx_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_slot_ff, rsp_evicted_ff, rsp_value_ff, rsp_hit_ff};

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above capacity");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> state_ff == ST_SCAN)
      else $error("compare outside scan");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      issue_active_ff |-> CNT_W'(issue_ptr_ff) < entry_count_ff)
      else $error("scan reads an invalid entry");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DECIDE))
      else $error("response without decision");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && ent_wr_en && op_ff == lfu_kvc_pkg::OP_STORE && !cache_full)
      |=> entry_count_ff == $past(entry_count_ff) + CNT_W'(1))
      else $error("fill did not advance entry count");

endmodule

`default_nettype wire
